[rtl/core/swbi_pkg.sv]
// shared types and constants for the stack with bottom increment
// no dependencies; used by swbi_exec, the top level and the checker by scoped names
`default_nettype none

package swbi_pkg;

  // command codes carried on in_tuser
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_INC  = 2'd2;

  // status codes carried on out_tuser
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CAP_W   = 7;

  localparam logic [WORD_W-1:0] EMPTY_WORD  = '1;
  localparam logic [CAP_W-1:0]  CAP_RESET   = 7'd64;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // latched command and the decisions taken when it was accepted
  typedef struct packed {
    logic [1:0]        cmd;
    logic [WORD_W-1:0] opv;
    logic              full;      // fill at usable capacity
    logic              empty;     // no entries in use
    logic              last;      // exactly one entry in use
    logic              inc_none;  // clamped count is zero
    logic              inc_top;   // clamped count reaches the top entry
  } op_t;

  // outcome of one command, applied at the end of the execute cycle
  typedef struct packed {
    logic [WORD_W-1:0] popped;
    logic [1:0]        status;
    logic              val_we;
    logic              inc_we;
    logic [WORD_W-1:0] inc_wdata;
    logic [WORD_W-1:0] top_inc_nxt;
    logic              fill_up;
    logic              fill_down;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/swbi_ram.sv]
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none

module swbi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/swbi_exec.sv]
// execute logic: turns a latched command and the memory read data into
// write enables, the new top increment and the result; uses swbi_pkg
`default_nettype none

module swbi_exec (
  input  wire  swbi_pkg::op_t                     op,
  input  wire  logic [swbi_pkg::WORD_W-1:0]       top_inc,
  input  wire  logic [swbi_pkg::WORD_W-1:0]       rd_val,
  input  wire  logic [swbi_pkg::WORD_W-1:0]       rd_inc,
  output       swbi_pkg::res_t                    res
);

  // decode the command
  always_comb begin
    res             = '0;
    res.status      = swbi_pkg::ST_DONE;
    res.top_inc_nxt = top_inc;
    unique case (op.cmd)
      swbi_pkg::CMD_PUSH: begin
        if (op.full) begin
          res.status = swbi_pkg::ST_FULL;
        end else begin
          // old top's pending increment moves into the memory
          res.val_we      = 1'b1;
          res.inc_we      = !op.empty;
          res.inc_wdata   = top_inc;
          res.top_inc_nxt = '0;
          res.fill_up     = 1'b1;
        end
      end
      swbi_pkg::CMD_POP: begin
        if (op.empty) begin
          res.popped = swbi_pkg::EMPTY_WORD;
          res.status = swbi_pkg::ST_EMPTY;
        end else begin
          // pending increment of the top passes down to the new top
          res.popped      = rd_val + top_inc;
          res.top_inc_nxt = op.last ? '0 : rd_inc + top_inc;
          res.fill_down   = 1'b1;
        end
      end
      swbi_pkg::CMD_INC: begin
        if (!op.inc_none) begin
          if (op.inc_top) begin
            res.top_inc_nxt = top_inc + op.opv;
          end else begin
            res.inc_we    = 1'b1;
            res.inc_wdata = rd_inc + op.opv;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/stack_with_bottom_increment_top.sv]
// top level of the stack with bottom increment: sequencer, fill counter,
// capacity register and result register; uses swbi_pkg, swbi_ram, swbi_exec
//
// Usage:
//   in_*  : one command per transaction. in_tuser selects push, pop or
//           increment; in_tdata carries the operand and the bottom count.
//   out_* : one result per command, popped word on out_tdata and status
//           on out_tuser.
//   cfg_* : capacity write, always ready; write only while the block is idle.
// Each command is read from the memories in the idle state when accepted,
// then added, written back and loaded into the result register in the
// execute state. No new command is accepted before the last one has left
// the execute state, since each takes a single read-modify-write pass
// through the two memories (stored words and lazy increment marks, one
// read port each). Increments are kept as marks on the highest touched
// entry and folded downward on pop: one access to each memory per command.
// Reset clears the fill count (stack empty) and sets the capacity to 64;
// memory contents are not cleared and are read only after a push wrote them.
// When the receiver stalls, the result holds in the output register; one
// more command may be accepted and read, then waits in the execute cycle.
`default_nettype none

module stack_with_bottom_increment_top #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command input
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [47:0] in_tdata,   // [31:0] operand_value, [47:32] bottom_count
  input  wire logic [1:0]  in_tuser,   // [1:0] command
  // result output
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // [31:0] popped_value
  output      logic [1:0]  out_tuser,  // [1:0] status
  // capacity write
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [6:0]  cfg_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned FW = (CW > swbi_pkg::CAP_W) ? CW : swbi_pkg::CAP_W;
  localparam int unsigned WW = swbi_pkg::WORD_W;

  swbi_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [WW-1:0]            top_inc_r, top_inc_nxt;
  logic [swbi_pkg::CAP_W-1:0] cap_r;
  swbi_pkg::op_t            op_r, op_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic                     out_valid_r;
  logic [WW-1:0]            out_data_r;
  logic [1:0]               out_status_r;

  logic                     in_acc;
  logic                     exec_done;
  logic [AW-1:0]            fill_m1;
  logic [AW-1:0]            fill_m2;
  logic                     full;
  logic [swbi_pkg::COUNT_W-1:0] cnt;
  logic [CW-1:0]            limit;
  logic [AW-1:0]            inc_idx;
  logic [AW-1:0]            inc_raddr;
  logic [WW-1:0]            rd_val;
  logic [WW-1:0]            rd_inc;
  swbi_pkg::res_t           res;

  assign in_tready = (state_r == swbi_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign exec_done = (state_r == swbi_pkg::S_EXEC) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  // decisions taken from the fill count at acceptance
  assign fill_m1 = AW'(fill_r - CW'(1));
  assign fill_m2 = AW'(fill_r - CW'(2));
  assign full    = (FW'(fill_r) >= FW'(cap_r)) || (fill_r >= CW'(DEPTH));
  assign cnt     = in_tdata[47:32];
  assign limit   = (cnt < swbi_pkg::COUNT_W'(fill_r)) ? cnt[CW-1:0] : fill_r;
  assign inc_idx = AW'(limit - CW'(1));

  always_comb begin
    op_nxt          = op_r;
    idx_nxt         = idx_r;
    if (in_acc) begin
      op_nxt.cmd      = in_tuser;
      op_nxt.opv      = in_tdata[31:0];
      op_nxt.full     = full;
      op_nxt.empty    = (fill_r == '0);
      op_nxt.last     = (fill_r == CW'(1));
      op_nxt.inc_none = (limit == '0);
      op_nxt.inc_top  = (limit == fill_r);
      idx_nxt         = (in_tuser == swbi_pkg::CMD_INC) ? inc_idx : fill_m1;
    end
  end

  // increment mark read address: entry below the top on pop
  assign inc_raddr = (in_tuser == swbi_pkg::CMD_POP) ? fill_m2 : inc_idx;

  // stored words
  swbi_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (exec_done && res.val_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (op_r.opv),
    .re    (in_acc),
    .raddr (fill_m1),
    .rdata (rd_val)
  );

  // lazy increment marks, valid below the top entry
  swbi_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_inc_ram (
    .clk   (clk),
    .we    (exec_done && res.inc_we),
    .waddr (idx_r),
    .wdata (res.inc_wdata),
    .re    (in_acc),
    .raddr (inc_raddr),
    .rdata (rd_inc)
  );

  swbi_exec u_exec (
    .op      (op_r),
    .top_inc (top_inc_r),
    .rd_val  (rd_val),
    .rd_inc  (rd_inc),
    .res     (res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swbi_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = swbi_pkg::S_EXEC;
        end
      end
      swbi_pkg::S_EXEC: begin
        if (exec_done) begin
          state_nxt = swbi_pkg::S_IDLE;
        end
      end
      default: state_nxt = swbi_pkg::S_IDLE;
    endcase
  end

  // fill count and top increment mark
  always_comb begin
    fill_nxt    = fill_r;
    top_inc_nxt = top_inc_r;
    if (exec_done) begin
      top_inc_nxt = res.top_inc_nxt;
      if (res.fill_up) begin
        fill_nxt = fill_r + CW'(1);
      end else if (res.fill_down) begin
        fill_nxt = fill_r - CW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swbi_pkg::S_IDLE;
      fill_r      <= '0;
      top_inc_r   <= '0;
      cap_r       <= swbi_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      top_inc_r <= top_inc_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (exec_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    idx_r <= idx_nxt;
    if (exec_done) begin
      out_data_r   <= res.popped;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

[rtl/core/swbi_checker.sv]
// port-level checker for the stack with bottom increment, bound to the top
// uses swbi_pkg status codes
`default_nettype none

module swbi_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // a pop on an empty stack returns all ones
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == swbi_pkg::ST_EMPTY |-> out_tdata == swbi_pkg::EMPTY_WORD)
    else $error("empty pop word wrong");

  // only pops carry a word; a dropped push returns zero
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == swbi_pkg::ST_FULL |-> out_tdata == '0)
    else $error("dropped push returned a word");

  // no status code beyond empty
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == swbi_pkg::ST_DONE || out_tuser == swbi_pkg::ST_FULL ||
                   out_tuser == swbi_pkg::ST_EMPTY)
    else $error("bad status code");

  // a command occupies the block for its execute cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted during execute");

endmodule

bind stack_with_bottom_increment_top swbi_checker u_swbi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
